[hdl/kbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbs_pkg
// Shared types, constants and helpers of the kinematic bicycle step unit.
// ----------------------------------------------------------------------------
package kbs_pkg;

  // Angle constants, Q16
  localparam logic signed [21:0] TWO_PI  = 22'sd411775;
  localparam logic signed [21:0] PI      = 22'sd205887;
  localparam logic signed [21:0] HALF_PI = 22'sd102944;
  localparam logic [18:0]        TWO_PI_U = 19'd411775;

  // Reciprocal of 2*pi for the modulo reduction, scaled by 2^RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 44;
  localparam logic [26:0] TWO_PI_RECIP = 27'((64'd1 << RECIP_SHIFT) / 64'd411775);

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = 2;
  localparam int unsigned DIV_BITS = 31;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_TIME_STEP     = 3'd0,
    REG_INV_WHEELBASE = 3'd1,
    REG_SPEED_LIM     = 3'd2,
    REG_STEER_LIM     = 3'd3,
    REG_ACCEL_LIM     = 3'd4
  } kbs_reg_e;

  typedef struct packed {
    logic [16:0] time_step;
    logic [20:0] inv_wheelbase;
    logic [30:0] speed_lim;
    logic [16:0] steer_lim;
    logic [30:0] accel_lim;
  } kbs_cfg_t;

  // Item handed from the front end to the back end
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
    logic signed [31:0] v;
    logic signed [31:0] vn;
    logic signed [31:0] rate;
    logic signed [33:0] zh;
    logic signed [33:0] zd;
    logic               negh;
    logic               negd;
  } fe_item_t;

  // Payload carried through the back-end pipeline
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
    logic signed [31:0] v;
    logic signed [31:0] vn;
    logic signed [31:0] rate;
    logic signed [33:0] hx;
    logic signed [33:0] hy;
    logic signed [33:0] hz;
    logic signed [33:0] sx;
    logic signed [33:0] sy;
    logic signed [33:0] sz;
    logic               negh;
    logic               negd;
    logic signed [35:0] pc;
    logic signed [35:0] ps;
    logic signed [39:0] dx;
    logic signed [39:0] dy;
    logic [48:0]        rem;
    logic [32:0]        dvs;
    logic [30:0]        quo;
    logic               qneg;
    logic               qsat;
    logic signed [31:0] r2;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oh;
  } bk_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = S32_MAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = S32_MIN;
    end
    return r;
  endfunction

  // Arctangent of 2^-i in Q2.30, truncated
  function automatic logic signed [33:0] atan_q30(input int unsigned idx);
    logic signed [33:0] r;
    unique case (idx)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/kbs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbs_front
// Accepts items, clamps the commands, reduces both angles modulo 2*pi and
// works out the new speed and the unscaled yaw rate.
// ----------------------------------------------------------------------------
module kbs_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire kbs_pkg::kbs_cfg_t  cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [191:0]       in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output kbs_pkg::fe_item_t       out_item_o
);

  // Reduced magnitude plus sign -> folded angle in Q2.30 and a flip flag
  function automatic logic [34:0] fold_angle(input logic [19:0] rmag, input logic neg);
    logic [19:0]        rm;
    logic signed [21:0] r;
    logic               flip;
    logic signed [33:0] z;
    rm = (rmag >= 20'(kbs_pkg::TWO_PI_U)) ? rmag - 20'(kbs_pkg::TWO_PI_U) : rmag;
    r = neg ? -$signed({2'b00, rm}) : $signed({2'b00, rm});
    if (r > kbs_pkg::PI) r = r - kbs_pkg::TWO_PI;
    if (r < -kbs_pkg::PI) r = r + kbs_pkg::TWO_PI;
    flip = 1'b0;
    if (r > kbs_pkg::HALF_PI) begin
      r = r - kbs_pkg::PI;
      flip = 1'b1;
    end else if (r < -kbs_pkg::HALF_PI) begin
      r = r + kbs_pkg::PI;
      flip = 1'b1;
    end
    z = 34'(r) <<< 14;
    return {flip, z};
  endfunction

  logic [4:0] vld_q;
  logic       en;

  assign en          = !vld_q[4] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // Stage 0: raw item
  logic signed [31:0] f0_x_q, f0_y_q, f0_h_q, f0_v_q, f0_st_q, f0_ac_q;

  // Stage 1: clamped commands and angle magnitudes
  logic signed [31:0] f1_x_q, f1_y_q, f1_h_q, f1_v_q, f1_a_q;
  logic [31:0]        f1_habs_q, f1_dabs_q;
  logic               f1_hneg_q, f1_dneg_q;
  logic signed [32:0] st_w, ac_w, lst_w, lac_w, dlt_d, acl_d;
  logic [31:0]        dlt32_w;

  always_comb begin
    st_w  = 33'(f0_st_q);
    ac_w  = 33'(f0_ac_q);
    lst_w = $signed({16'b0, cfg_i.steer_lim});
    lac_w = $signed({2'b0, cfg_i.accel_lim});
    dlt_d = st_w;
    if (st_w > lst_w) dlt_d = lst_w;
    else if (st_w < -lst_w) dlt_d = -lst_w;
    acl_d = ac_w;
    if (ac_w > lac_w) acl_d = lac_w;
    else if (ac_w < -lac_w) acl_d = -lac_w;
    dlt32_w = dlt_d[31:0];
  end

  // Stage 2: quotient estimates and products
  logic signed [31:0] f2_x_q, f2_y_q, f2_h_q, f2_v_q;
  logic [31:0]        f2_habs_q, f2_dabs_q;
  logic               f2_hneg_q, f2_dneg_q;
  logic [12:0]        f2_qh_q, f2_qd_q;
  logic signed [49:0] f2_adt_q;
  logic signed [53:0] f2_vw_q;
  logic [58:0]        ph_w, pd_w;

  assign ph_w = 59'(f1_habs_q) * 59'(kbs_pkg::TWO_PI_RECIP);
  assign pd_w = 59'(f1_dabs_q) * 59'(kbs_pkg::TWO_PI_RECIP);

  // Stage 3: remainders, new speed, yaw rate before steering
  logic signed [31:0] f3_x_q, f3_y_q, f3_h_q, f3_v_q, f3_vn_q, f3_rate_q;
  logic [19:0]        f3_rh_q, f3_rd_q;
  logic               f3_hneg_q, f3_dneg_q;
  logic [32:0]        dh_w, dd_w;
  logic signed [33:0] vsum_w, lsp_w, vn_w;

  always_comb begin
    dh_w   = {1'b0, f2_habs_q} - (33'(f2_qh_q) * 33'(kbs_pkg::TWO_PI_U));
    dd_w   = {1'b0, f2_dabs_q} - (33'(f2_qd_q) * 33'(kbs_pkg::TWO_PI_U));
    vsum_w = 34'(f2_v_q) + 34'(f2_adt_q >>> 16);
    lsp_w  = $signed({3'b0, cfg_i.speed_lim});
    vn_w   = vsum_w;
    if (vsum_w > lsp_w) vn_w = lsp_w;
    else if (vsum_w < -lsp_w) vn_w = -lsp_w;
  end

  // Stage 4: folded angles
  kbs_pkg::fe_item_t f4_q;
  logic [34:0]       fh_w, fd_w;

  assign fh_w = fold_angle(f3_rh_q, f3_hneg_q);
  assign fd_w = fold_angle(f3_rd_q, f3_dneg_q);
  assign out_item_o = f4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_x_q  <= in_data_i[31:0];
      f0_y_q  <= in_data_i[63:32];
      f0_h_q  <= in_data_i[95:64];
      f0_v_q  <= in_data_i[127:96];
      f0_st_q <= in_data_i[159:128];
      f0_ac_q <= in_data_i[191:160];

      f1_x_q    <= f0_x_q;
      f1_y_q    <= f0_y_q;
      f1_h_q    <= f0_h_q;
      f1_v_q    <= f0_v_q;
      f1_a_q    <= acl_d[31:0];
      f1_hneg_q <= f0_h_q[31];
      f1_habs_q <= f0_h_q[31] ? (~f0_h_q + 32'd1) : f0_h_q;
      f1_dneg_q <= dlt32_w[31];
      f1_dabs_q <= dlt32_w[31] ? (~dlt32_w + 32'd1) : dlt32_w;

      f2_x_q    <= f1_x_q;
      f2_y_q    <= f1_y_q;
      f2_h_q    <= f1_h_q;
      f2_v_q    <= f1_v_q;
      f2_habs_q <= f1_habs_q;
      f2_dabs_q <= f1_dabs_q;
      f2_hneg_q <= f1_hneg_q;
      f2_dneg_q <= f1_dneg_q;
      f2_qh_q   <= ph_w[kbs_pkg::RECIP_SHIFT +: 13];
      f2_qd_q   <= pd_w[kbs_pkg::RECIP_SHIFT +: 13];
      f2_adt_q  <= f1_a_q * $signed({1'b0, cfg_i.time_step});
      f2_vw_q   <= f1_v_q * $signed({1'b0, cfg_i.inv_wheelbase});

      f3_x_q    <= f2_x_q;
      f3_y_q    <= f2_y_q;
      f3_h_q    <= f2_h_q;
      f3_v_q    <= f2_v_q;
      f3_vn_q   <= vn_w[31:0];
      f3_rate_q <= kbs_pkg::sat32(64'(f2_vw_q >>> 16));
      f3_rh_q   <= dh_w[19:0];
      f3_rd_q   <= dd_w[19:0];
      f3_hneg_q <= f2_hneg_q;
      f3_dneg_q <= f2_dneg_q;

      f4_q.x    <= f3_x_q;
      f4_q.y    <= f3_y_q;
      f4_q.h    <= f3_h_q;
      f4_q.v    <= f3_v_q;
      f4_q.vn   <= f3_vn_q;
      f4_q.rate <= f3_rate_q;
      f4_q.negh <= fh_w[34];
      f4_q.zh   <= fh_w[33:0];
      f4_q.negd <= fd_w[34];
      f4_q.zd   <= fd_w[33:0];
    end
  end

endmodule
`default_nettype wire

[hdl/kbs_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbs_fifo
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module kbs_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire kbs_pkg::fe_item_t push_item_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output kbs_pkg::fe_item_t      pop_item_o
);

  kbs_pkg::fe_item_t            mem_q [kbs_pkg::QUEUE_DEPTH];
  logic [kbs_pkg::QUEUE_AW-1:0] wr_q, rd_q;
  logic [kbs_pkg::QUEUE_AW:0]   cnt_q;
  logic                         push, pop;

  assign push_ready_o = (cnt_q != (kbs_pkg::QUEUE_AW + 1)'(kbs_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule
`default_nettype wire

[hdl/kbs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbs_back
// Two CORDIC pipelines, a bit-per-stage divider for tan(steer) and the
// Euler update with saturation.
// ----------------------------------------------------------------------------
module kbs_back #(
  parameter int unsigned ITERS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kbs_pkg::kbs_cfg_t cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kbs_pkg::fe_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [31:0]     next_x_o,
  output logic signed [31:0]     next_y_o,
  output logic signed [31:0]     next_heading_o,
  output logic signed [31:0]     next_speed_o
);

  localparam int unsigned POST = ITERS + 1;
  localparam int unsigned DIV0 = ITERS + 2;
  localparam int unsigned DIVN = DIV0 + kbs_pkg::DIV_BITS - 1;
  localparam int unsigned TANS = DIVN + 1;
  localparam int unsigned LAST = TANS + 1;
  localparam int unsigned NS   = LAST + 1;

  kbs_pkg::bk_t st_q [NS];
  logic [NS-1:0] vld_q;
  logic          en;
  logic signed [17:0] dt_w;

  assign en          = !vld_q[LAST] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAST];
  assign dt_w        = $signed({1'b0, cfg_i.time_step});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // Stage 0: load CORDIC start values
  kbs_pkg::bk_t ld_d;
  always_comb begin
    ld_d      = '0;
    ld_d.x    = in_item_i.x;
    ld_d.y    = in_item_i.y;
    ld_d.h    = in_item_i.h;
    ld_d.v    = in_item_i.v;
    ld_d.vn   = in_item_i.vn;
    ld_d.rate = in_item_i.rate;
    ld_d.hx   = kbs_pkg::CORDIC_START;
    ld_d.hz   = in_item_i.zh;
    ld_d.sx   = kbs_pkg::CORDIC_START;
    ld_d.sz   = in_item_i.zd;
    ld_d.negh = in_item_i.negh;
    ld_d.negd = in_item_i.negd;
  end

  always_ff @(posedge clk_i) begin
    if (en) st_q[0] <= ld_d;
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    kbs_pkg::bk_t p, nxt;
    assign p = st_q[s-1];

    if (s <= ITERS) begin : g_cordic
      localparam int unsigned I = s - 1;
      localparam logic signed [33:0] ATAN = kbs_pkg::atan_q30(I);
      always_comb begin
        nxt = p;
        if (!p.hz[33]) begin
          nxt.hx = p.hx - (p.hy >>> I);
          nxt.hy = p.hy + (p.hx >>> I);
          nxt.hz = p.hz - ATAN;
        end else begin
          nxt.hx = p.hx + (p.hy >>> I);
          nxt.hy = p.hy - (p.hx >>> I);
          nxt.hz = p.hz + ATAN;
        end
        if (!p.sz[33]) begin
          nxt.sx = p.sx - (p.sy >>> I);
          nxt.sy = p.sy + (p.sx >>> I);
          nxt.sz = p.sz - ATAN;
        end else begin
          nxt.sx = p.sx + (p.sy >>> I);
          nxt.sy = p.sy - (p.sx >>> I);
          nxt.sz = p.sz + ATAN;
        end
      end
    end else if (s == POST) begin : g_post
      logic signed [33:0] ch, sh, cd, sd, sa, ca;
      logic signed [65:0] mc, ms;
      always_comb begin
        nxt = p;
        ch  = p.negh ? -p.hx : p.hx;
        sh  = p.negh ? -p.hy : p.hy;
        cd  = p.negd ? -p.sx : p.sx;
        sd  = p.negd ? -p.sy : p.sy;
        mc  = p.v * ch;
        ms  = p.v * sh;
        nxt.pc = 36'(mc >>> 30);
        nxt.ps = 36'(ms >>> 30);
        sa  = sd[33] ? -sd : sd;
        ca  = cd[33] ? -cd : cd;
        nxt.qsat = {15'b0, sa[32:0]} >= {ca[32:0], 15'b0};
        nxt.qneg = sd[33] ^ cd[33];
        nxt.rem  = {sa[32:0], 16'b0};
        nxt.dvs  = ca[32:0];
        nxt.quo  = '0;
      end
    end else if (s <= DIVN) begin : g_div
      localparam int unsigned K = DIVN - s;
      logic [63:0]        r64, d64;
      logic signed [53:0] ex, ey;
      always_comb begin
        nxt = p;
        r64 = 64'(p.rem);
        d64 = 64'(p.dvs) << K;
        if (r64 >= d64) begin
          nxt.rem    = 49'(r64 - d64);
          nxt.quo[K] = 1'b1;
        end
        ex = p.pc * dt_w;
        ey = p.ps * dt_w;
        // position deltas only on the first divider stage
        if (s == DIV0) begin
          nxt.dx = 40'(ex >>> 16);
          nxt.dy = 40'(ey >>> 16);
        end
      end
    end else if (s == TANS) begin : g_tan
      logic signed [31:0] tn, qv;
      logic signed [63:0] pr;
      always_comb begin
        nxt = p;
        qv  = $signed({1'b0, p.quo});
        if (p.qsat) tn = p.qneg ? kbs_pkg::S32_MIN : kbs_pkg::S32_MAX;
        else tn = p.qneg ? -qv : qv;
        pr  = p.rate * tn;
        nxt.r2 = kbs_pkg::sat32(pr >>> 16);
      end
    end else begin : g_out
      logic signed [49:0] ph;
      logic signed [33:0] dh;
      always_comb begin
        nxt = p;
        ph  = p.r2 * dt_w;
        dh  = 34'(ph >>> 16);
        nxt.ox = kbs_pkg::sat32(64'(p.x) + 64'(p.dx));
        nxt.oy = kbs_pkg::sat32(64'(p.y) + 64'(p.dy));
        nxt.oh = kbs_pkg::sat32(64'(p.h) + 64'(dh));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) st_q[s] <= nxt;
    end
  end

  assign next_x_o       = st_q[LAST].ox;
  assign next_y_o       = st_q[LAST].oy;
  assign next_heading_o = st_q[LAST].oh;
  assign next_speed_o   = st_q[LAST].vn;

endmodule
`default_nettype wire

[hdl/kinematic_bicycle_step_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kinematic_bicycle_step_unit
// One forward Euler step of the kinematic bicycle model in Q15.16.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled; one result per item, in order. The
// front end (5 stages: clamp, reciprocal-multiply modulo 2*pi, fold) feeds a
// 4-entry queue; the back end holds two CORDIC pipelines of TRIG_ITERATIONS
// stages, a divider that settles one quotient bit per stage (31 stages) and
// the update stages, TRIG_ITERATIONS + 35 stages in all. The back end pipeline
// stalls as a whole while a result waits on m_axis_tready; the queue lets
// the front end keep accepting meanwhile.
// Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i and take
// effect on the following item; write them only while no item is in flight.
module kinematic_bicycle_step_unit #(
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, heading, speed, steer_cmd, accel_cmd (32 bits each)
  input  wire logic [191:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_x, next_y, next_heading, next_speed (32 bits each)
  output logic [127:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [30:0]  cfg_wdata_i
);

  kbs_pkg::kbs_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step     <= 17'd6554;
      cfg_q.inv_wheelbase <= 21'd26214;
      cfg_q.speed_lim     <= 31'd1310720;
      cfg_q.steer_lim     <= 17'd32768;
      cfg_q.accel_lim     <= 31'd196608;
    end else if (cfg_we_i) begin
      unique case (kbs_pkg::kbs_reg_e'(cfg_index_i))
        kbs_pkg::REG_TIME_STEP:     cfg_q.time_step     <= cfg_wdata_i[16:0];
        kbs_pkg::REG_INV_WHEELBASE: cfg_q.inv_wheelbase <= cfg_wdata_i[20:0];
        kbs_pkg::REG_SPEED_LIM:     cfg_q.speed_lim     <= cfg_wdata_i;
        kbs_pkg::REG_STEER_LIM:     cfg_q.steer_lim     <= cfg_wdata_i[16:0];
        kbs_pkg::REG_ACCEL_LIM:     cfg_q.accel_lim     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic              fe_valid, fe_ready, bk_valid, bk_ready;
  kbs_pkg::fe_item_t fe_item, bk_item;
  logic signed [31:0] nx, ny, nh, nv;

  kbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_item_o  (fe_item)
  );

  kbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_item_i  (fe_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  kbs_back #(
    .ITERS (TRIG_ITERATIONS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (bk_valid),
    .in_ready_o     (bk_ready),
    .in_item_i      (bk_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .next_x_o       (nx),
    .next_y_o       (ny),
    .next_heading_o (nh),
    .next_speed_o   (nv)
  );

  assign m_axis_tdata = {nv, nh, ny, nx};

  // A stalled result must freeze the back end: nothing leaves the queue.
  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !(bk_valid && bk_ready))
    else $error("queue popped while result stalled");

  // A full queue with a waiting front-end item must hold off the input.
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fe_valid && !fe_ready) |-> !s_axis_tready)
    else $error("input accepted while front end blocked");

endmodule
`default_nettype wire
